/* hdl/pwz_pkg.sv */
// Shared constants, codes and types for the PID autotune block.
package pwz_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DIV_W = 49;

	localparam logic [31:0] K_1P5     = 32'd98304;
	localparam logic [31:0] K_2       = 32'd131072;
	localparam logic [31:0] K_0P6     = 32'd39322;
	localparam logic [31:0] K_0P01    = 32'd655;
	localparam logic [31:0] K_0P5     = 32'd32768;
	localparam logic [33:0] K_0P05    = 34'd3277;
	localparam logic [31:0] K_0P7     = 32'd45875;
	localparam logic [31:0] K_0P6_2X  = 32'd39322;
	localparam logic [31:0] K_300     = 32'd19660800;
	localparam logic [31:0] K_0P8     = 32'd52429;
	localparam logic [31:0] K_1P3     = 32'd85197;
	localparam logic [31:0] K_8       = 32'd524288;
	localparam logic signed [49:0] K_INT_LIM = 50'sd3276800;
	localparam logic signed [14:0] K_TEST_AMP = 15'sd9830;
	localparam logic [3:0] PEAKS_ZN = 4'd6;
	localparam logic [3:0] PEAKS_TO = 4'd3;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_START = 2'd1,
		ACT_STOP  = 2'd2,
		ACT_NONE  = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		REG_INIT_KP = 3'd0,
		REG_INIT_KI = 3'd1,
		REG_INIT_KD = 3'd2,
		REG_MIN_KP  = 3'd3,
		REG_MAX_KP  = 3'd4,
		REG_MAX_KI  = 3'd5,
		REG_MAX_KD  = 3'd6,
		REG_HALF_T  = 3'd7
	} reg_t;

	typedef enum logic [29:0] {
		ST_IDLE    = 30'h1 << 0,
		ST_ST_MUL  = 30'h1 << 1,
		ST_ST_W    = 30'h1 << 2,
		ST_DET     = 30'h1 << 3,
		ST_PA1     = 30'h1 << 4,
		ST_PA2     = 30'h1 << 5,
		ST_PA3     = 30'h1 << 6,
		ST_ZNCHK   = 30'h1 << 7,
		ST_ZN1     = 30'h1 << 8,
		ST_ZN2     = 30'h1 << 9,
		ST_ZN3     = 30'h1 << 10,
		ST_ZN4     = 30'h1 << 11,
		ST_ZN5     = 30'h1 << 12,
		ST_ZN6     = 30'h1 << 13,
		ST_AMP     = 30'h1 << 14,
		ST_AMP_MUL = 30'h1 << 15,
		ST_AMP_W   = 30'h1 << 16,
		ST_TO      = 30'h1 << 17,
		ST_TO_MUL  = 30'h1 << 18,
		ST_TO_W    = 30'h1 << 19,
		ST_P       = 30'h1 << 20,
		ST_E       = 30'h1 << 21,
		ST_A       = 30'h1 << 22,
		ST_I       = 30'h1 << 23,
		ST_D       = 30'h1 << 24,
		ST_DW      = 30'h1 << 25,
		ST_DM      = 30'h1 << 26,
		ST_DS      = 30'h1 << 27,
		ST_F       = 30'h1 << 28,
		ST_OUT     = 30'h1 << 29
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [31:0]      divisor;
	} div_req_t;

endpackage

/* hdl/pid_with_ziegler_nichols_autotune.sv */
// Top level: PID tick sequencer with one shared multiplier and an iterative divider.
//
//  channel   dir  beat on            contents
//  s_*       in   s_tvalid&s_tready  tuser: action; tdata: error_in, delta_time
//  m_*       out  m_tvalid&m_tready  tdata: drive, test_drive, flags, kp, ki, kd
//  cfg_*     in   cfg_we             cfg_index selects register, cfg_data value
//
// A tick waits on the divider for the derivative when delta_time is nonzero; a tick
// that ends tuning also waits on it for the Z-N gains (gain division). One item at
// a time: s_tready is high only while idle, and the result holds in the output
// register until taken.
// Reset loads the register defaults and the initial controller state at once.
module pid_with_ziegler_nichols_autotune import pwz_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [47:0]   s_tdata,   // error_in[31:0], delta_time[47:32]
	input  logic [1:0]    s_tuser,   // action[1:0]
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [151:0]  m_tdata,   // drive[31:0], test_drive[46:32], tuning_active[47],
	                                 // tuning_finished[48], kp_now[80:49], ki_now[112:81],
	                                 // kd_now[144:113], zero[151:145]
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	state_t state_q, state_d;

	logic [31:0]        cfg_q [8];
	logic signed [31:0] e_q, last_q, integ_q, der_q, drive_q;
	logic [15:0]        dt_q;
	logic [31:0]        kp_q, ki_q, kd_q, osc_q, amp_q, lpk_q, pa_q, ug_q, tt_q;
	logic               loaded_q, tuning_q, tuned_q, rf_q, tpos_q, dneg_q;
	logic [3:0]         pt_q;
	logic signed [32:0] d_q;
	logic signed [51:0] acc_q;
	logic signed [14:0] test_q;
	logic signed [65:0] prod_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [49:0] prod_sh;
	logic               rising;
	logic [32:0]        osc_sum, tt_sum, peak, mag;
	logic [31:0]        osc_new, amp_new, tt_new, kp_zn;
	logic signed [32:0] dsub, diff;
	logic               pvok;
	logic [3:0]         pt_inc;
	logic signed [51:0] pa_sum;
	logic signed [49:0] int_sum;
	logic               div_done;
	logic [DIV_W-1:0]   div_q;
	div_req_t           div_req;

	function automatic logic [31:0] sat32(input logic [49:0] x);
		return (|x[49:32]) ? 32'hFFFF_FFFF : x[31:0];
	endfunction

	function automatic logic [31:0] clampg(input logic [49:0] x, input logic [31:0] lo,
			input logic [31:0] hi);
		if (x < {18'b0, lo}) return lo;
		if (x < {18'b0, hi}) return x[31:0];
		return hi;
	endfunction

	assign prod_sh = prod_q[FRAC_BITS+49:FRAC_BITS];
	assign rising  = e_q > last_q;
	assign osc_sum = {1'b0, osc_q} + {17'b0, dt_q};
	assign osc_new = osc_sum[32] ? 32'hFFFF_FFFF : osc_sum[31:0];
	assign peak    = e_q[31] ? 33'(-{e_q[31], e_q}) : {1'b0, e_q};
	assign amp_new = (peak > {1'b0, amp_q}) ? peak[31:0] : amp_q;
	assign dsub    = $signed({1'b0, osc_new}) - $signed({1'b0, lpk_q});
	assign pvok    = (pt_q != 4'd0) && (peak > {1'b0, K_2}) &&
		($signed({dsub, 1'b0}) > $signed(K_0P05));
	assign pt_inc  = (pt_q == 4'hF) ? pt_q : pt_q + 4'd1;
	assign pa_sum  = acc_q + prod_q[51:0];
	assign int_sum = {{18{integ_q[31]}}, integ_q} + prod_sh;
	assign diff    = {e_q[31], e_q} - {last_q[31], last_q};
	assign mag     = diff[32] ? 33'(-diff) : diff;
	assign tt_sum  = {1'b0, tt_q} + {17'b0, dt_q};
	assign tt_new  = tt_sum[32] ? 32'hFFFF_FFFF : tt_sum[31:0];
	assign kp_zn   = clampg(prod_sh, cfg_q[REG_MIN_KP], cfg_q[REG_MAX_KP]);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_ST_MUL:  begin mul_a = $signed({1'b0, kp_q}); mul_b = $signed({1'b0, K_1P5}); end
			ST_PA1:     begin mul_a = $signed({1'b0, pa_q}); mul_b = $signed({1'b0, K_0P7}); end
			ST_PA2:     begin mul_a = d_q; mul_b = $signed({1'b0, K_0P6_2X}); end
			ST_ZN2:     begin mul_a = $signed({1'b0, ug_q}); mul_b = $signed({1'b0, K_0P6}); end
			ST_ZN5:     begin mul_a = $signed({1'b0, kp_q}); mul_b = $signed({1'b0, pa_q}); end
			ST_AMP_MUL: begin mul_a = $signed({1'b0, kp_q}); mul_b = $signed({1'b0, K_0P8}); end
			ST_TO_MUL:  begin mul_a = $signed({1'b0, kp_q}); mul_b = $signed({1'b0, K_1P3}); end
			ST_P:       begin mul_a = $signed({1'b0, kp_q}); mul_b = {e_q[31], e_q}; end
			ST_E:       begin mul_a = {e_q[31], e_q}; mul_b = $signed({17'b0, dt_q}); end
			ST_I:       begin mul_a = $signed({1'b0, ki_q}); mul_b = {integ_q[31], integ_q}; end
			ST_DM:      begin mul_a = $signed({1'b0, kd_q}); mul_b = {der_q[31], der_q}; end
			default:    begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = {mag, 16'b0};
		div_req.divisor  = {16'b0, dt_q};
		if (state_q == ST_ZN3) begin
			div_req.start    = 1'b1;
			div_req.dividend = {kp_zn, 17'b0};
			div_req.divisor  = pa_q;
		end else if (state_q == ST_ZN4) begin
			div_req.divisor  = pa_q;
		end else if (state_q == ST_D) begin
			div_req.start    = dt_q != 16'd0;
		end
	end

	pwz_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					unique case (act_t'(s_tuser))
						ACT_TICK:  state_d = tuning_q ? ST_DET : ST_P;
						ACT_START: state_d = ST_ST_MUL;
						ACT_STOP:  state_d = ST_OUT;
						ACT_NONE:  state_d = ST_OUT;
						default:   state_d = ST_OUT;
					endcase
				end
			end
			ST_ST_MUL:  state_d = ST_ST_W;
			ST_ST_W:    state_d = ST_OUT;
			ST_DET:     state_d = (rising != rf_q) ? (pvok ? ST_PA1 : ST_ZNCHK) : ST_AMP;
			ST_PA1:     state_d = ST_PA2;
			ST_PA2:     state_d = ST_PA3;
			ST_PA3:     state_d = ST_ZNCHK;
			ST_ZNCHK:   state_d = (pt_q >= PEAKS_ZN && amp_q > K_2) ? ST_ZN1 : ST_AMP;
			ST_ZN1:     state_d = ST_ZN2;
			ST_ZN2:     state_d = ST_ZN3;
			ST_ZN3:     state_d = ST_ZN4;
			ST_ZN4:     state_d = div_done ? ST_ZN5 : ST_ZN4;
			ST_ZN5:     state_d = ST_ZN6;
			ST_ZN6:     state_d = ST_P;
			ST_AMP:     state_d = (amp_q > K_300) ? ST_AMP_MUL : ST_TO;
			ST_AMP_MUL: state_d = ST_AMP_W;
			ST_AMP_W:   state_d = ST_TO;
			ST_TO:      state_d = (osc_q > K_8 && pt_q < PEAKS_TO) ? ST_TO_MUL : ST_P;
			ST_TO_MUL:  state_d = ST_TO_W;
			ST_TO_W:    state_d = ST_P;
			ST_P:       state_d = ST_E;
			ST_E:       state_d = ST_A;
			ST_A:       state_d = ST_I;
			ST_I:       state_d = ST_D;
			ST_D:       state_d = (dt_q != 16'd0) ? ST_DW : ST_F;
			ST_DW:      state_d = div_done ? ST_DM : ST_DW;
			ST_DM:      state_d = ST_DS;
			ST_DS:      state_d = ST_F;
			ST_F:       state_d = ST_OUT;
			ST_OUT:     state_d = m_tready ? ST_IDLE : ST_OUT;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cfg_q[REG_INIT_KP] <= 32'd65536;
			cfg_q[REG_INIT_KI] <= 32'd0;
			cfg_q[REG_INIT_KD] <= 32'd0;
			cfg_q[REG_MIN_KP]  <= 32'd6554;
			cfg_q[REG_MAX_KP]  <= 32'd6553600;
			cfg_q[REG_MAX_KI]  <= 32'd6553600;
			cfg_q[REG_MAX_KD]  <= 32'd6553600;
			cfg_q[REG_HALF_T]  <= 32'd65536;
			e_q      <= '0;
			dt_q     <= '0;
			integ_q  <= '0;
			last_q   <= '0;
			kp_q     <= 32'd65536;
			ki_q     <= '0;
			kd_q     <= '0;
			loaded_q <= 1'b0;
			tuning_q <= 1'b0;
			tuned_q  <= 1'b0;
			osc_q    <= '0;
			pt_q     <= '0;
			amp_q    <= '0;
			rf_q     <= 1'b1;
			lpk_q    <= '0;
			pa_q     <= '0;
			ug_q     <= '0;
			tt_q     <= '0;
			tpos_q   <= 1'b1;
			d_q      <= '0;
			dneg_q   <= 1'b0;
			acc_q    <= '0;
			der_q    <= '0;
			drive_q  <= '0;
			test_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) cfg_q[cfg_index] <= cfg_data;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						e_q     <= $signed(s_tdata[31:0]);
						dt_q    <= s_tdata[47:32];
						drive_q <= '0;
						test_q  <= '0;
						if (!loaded_q) begin
							kp_q     <= cfg_q[REG_INIT_KP];
							ki_q     <= cfg_q[REG_INIT_KI];
							kd_q     <= cfg_q[REG_INIT_KD];
							loaded_q <= 1'b1;
						end
						if (act_t'(s_tuser) == ACT_STOP) begin
							tuning_q <= 1'b0;
							tuned_q  <= 1'b1;
							integ_q  <= '0;
							last_q   <= '0;
						end
					end
				end
				ST_ST_W: begin
					kp_q     <= (sat32(prod_sh) < K_2) ? K_2 : sat32(prod_sh);
					ki_q     <= '0;
					kd_q     <= '0;
					tuning_q <= 1'b1;
					tuned_q  <= 1'b0;
					osc_q    <= '0;
					pt_q     <= '0;
					amp_q    <= '0;
					rf_q     <= 1'b1;
					tt_q     <= '0;
					tpos_q   <= 1'b1;
					lpk_q    <= '0;
					pa_q     <= '0;
					integ_q  <= '0;
					last_q   <= '0;
				end
				ST_DET: begin
					osc_q <= osc_new;
					if (rising != rf_q) begin
						amp_q <= amp_new;
						d_q   <= dsub;
						lpk_q <= osc_new;
						pt_q  <= pt_inc;
						rf_q  <= rising;
					end
				end
				ST_PA2: acc_q <= prod_q[51:0];
				ST_PA3: pa_q <= sat32(50'(pa_sum[51:FRAC_BITS]));
				ST_ZNCHK: begin
					if (pt_q >= PEAKS_ZN && amp_q > K_2) ug_q <= kp_q;
				end
				ST_ZN1: begin
					if (pa_q < K_0P01) pa_q <= K_0P5;
				end
				ST_ZN3: kp_q <= kp_zn;
				ST_ZN4: begin
					if (div_done) ki_q <= clampg({1'b0, div_q}, 32'd0, cfg_q[REG_MAX_KI]);
				end
				ST_ZN6: begin
					kd_q     <= clampg(50'(prod_q[65:FRAC_BITS+3]), 32'd0, cfg_q[REG_MAX_KD]);
					tuning_q <= 1'b0;
					tuned_q  <= 1'b1;
					integ_q  <= '0;
					last_q   <= '0;
				end
				ST_AMP_W: begin
					kp_q  <= sat32(prod_sh);
					amp_q <= '0;
				end
				ST_TO_W: begin
					kp_q  <= clampg({18'b0, sat32(prod_sh)}, cfg_q[REG_MIN_KP], cfg_q[REG_MAX_KP]);
					osc_q <= '0;
					pt_q  <= '0;
				end
				ST_E: acc_q <= 52'(prod_sh);
				ST_A: begin
					if (int_sum < -K_INT_LIM) integ_q <= 32'(-K_INT_LIM);
					else if (int_sum > K_INT_LIM) integ_q <= 32'(K_INT_LIM);
					else integ_q <= int_sum[31:0];
				end
				ST_D: begin
					acc_q  <= acc_q + 52'(prod_sh);
					dneg_q <= diff[32];
				end
				ST_DW: begin
					if (div_done) begin
						if (dneg_q) der_q <= (div_q > DIV_W'(33'h8000_0000)) ?
							32'sh8000_0000 : 32'(-div_q[31:0]);
						else der_q <= (div_q > DIV_W'(32'h7FFF_FFFF)) ?
							32'sh7FFF_FFFF : $signed(div_q[31:0]);
					end
				end
				ST_DS: acc_q <= acc_q + 52'(prod_sh);
				ST_F: begin
					last_q <= e_q;
					if (acc_q < -52'sh8000_0000) drive_q <= 32'sh8000_0000;
					else if (acc_q > 52'sh7FFF_FFFF) drive_q <= 32'sh7FFF_FFFF;
					else drive_q <= acc_q[31:0];
					if (tuning_q) begin
						// flip sign once the half period has run out
						if (tt_new >= cfg_q[REG_HALF_T]) begin
							tt_q   <= '0;
							tpos_q <= ~tpos_q;
							test_q <= tpos_q ? -K_TEST_AMP : K_TEST_AMP;
						end else begin
							tt_q   <= tt_new;
							test_q <= tpos_q ? K_TEST_AMP : -K_TEST_AMP;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = state_q == ST_OUT;
	assign m_tdata  = {7'b0, kd_q, ki_q, kp_q, tuned_q, tuning_q, test_q, drive_q};

`ifndef SYNTHESIS
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_tvalid && s_tready)) else $error("input and output open together");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DW || state_q == ST_ZN4))
		else $error("divider result outside a wait state");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(tuning_q && tuned_q)) else $error("tuning and tuned both set");
	a_integ: assert property (@(posedge clk) disable iff (!arst_n)
		(integ_q <= 32'(K_INT_LIM)) && (integ_q >= 32'(-K_INT_LIM)))
		else $error("integral beyond clamp");
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !m_tready) |=> state_q == ST_OUT)
		else $error("result dropped while stalled");
`endif

endmodule

/* hdl/pwz_div.sv */
// Restoring divider, one quotient bit per cycle.
module pwz_div import pwz_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic [5:0]       count_q;
	logic             busy_q;
	logic             done_q;
	logic [31:0]      rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [32:0]      rem_sh;
	logic             fits;

	assign rem_sh = {rem_q, quo_q[DIV_W-1]};
	assign fits = rem_sh >= {1'b0, req.divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				count_q <= 6'(DIV_W);
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				count_q <= count_q - 6'd1;
				if (count_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(rem_sh - {1'b0, req.divisor}) : rem_sh[31:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule
